// ===== hw/rtl/rsti_pkg.sv =====
package rsti_pkg;

   localparam int CoordWidth = 32;
   localparam int EdgeWidth  = 33;
   localparam int ProdWidth  = 66;
   localparam int CrossWidth = 67;
   localparam int SplitLow   = 34;
   localparam int DotWidth   = 104;
   localparam int CmpWidth   = 106;
   localparam int ThrWidth   = 40;
   localparam int CsrIdxWidth = 3;
   localparam logic [ThrWidth-1:0] ThrReset = 40'd281474977;

   typedef enum logic [2:0] {
      REASON_HIT      = 3'd0,
      REASON_PARALLEL = 3'd1,
      REASON_U_OUT    = 3'd2,
      REASON_V_OUT    = 3'd3,
      REASON_T_OUT    = 3'd4
   } reason_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_TEST_MODE     = 3'd0,
      CSR_START_X       = 3'd1,
      CSR_START_Y       = 3'd2,
      CSR_START_Z       = 3'd3,
      CSR_SECOND_X      = 3'd4,
      CSR_SECOND_Y      = 3'd5,
      CSR_SECOND_Z      = 3'd6,
      CSR_DET_THRESHOLD = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic adv_mul;
      logic adv_sum;
      logic adv_out;
   } dot_ctrl_type;

   function automatic logic signed [EdgeWidth-1:0] ext33(input logic signed [CoordWidth-1:0] x);
      ext33 = EdgeWidth'(x);
   endfunction

endpackage

// ===== hw/rtl/rsti_dot3.sv =====
module rsti_dot3 (
   input  logic                                      clock,
   input  rsti_pkg::dot_ctrl_type                    ctrl,
   input  logic signed [rsti_pkg::EdgeWidth-1:0]     a [3],
   input  logic signed [rsti_pkg::CrossWidth-1:0]    b [3],
   output logic signed [rsti_pkg::DotWidth-1:0]      dot
);

   localparam int LoProd = rsti_pkg::EdgeWidth + rsti_pkg::SplitLow + 1;
   localparam int HiProd = rsti_pkg::EdgeWidth + rsti_pkg::CrossWidth - rsti_pkg::SplitLow;
   localparam int LoSum  = LoProd + 2;
   localparam int HiSum  = HiProd + 2;

   logic signed [LoProd-1:0] plo_in [3];
   logic signed [LoProd-1:0] plo_ff [3];
   logic signed [HiProd-1:0] phi_in [3];
   logic signed [HiProd-1:0] phi_ff [3];
   logic signed [LoSum-1:0]  slo_in;
   logic signed [LoSum-1:0]  slo_ff;
   logic signed [HiSum-1:0]  shi_in;
   logic signed [HiSum-1:0]  shi_ff;
   logic signed [rsti_pkg::DotWidth-1:0] dot_in;
   logic signed [rsti_pkg::DotWidth-1:0] dot_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         plo_in[i] = a[i] * $signed({1'b0, b[i][rsti_pkg::SplitLow-1:0]});
         phi_in[i] = a[i] * $signed(b[i][rsti_pkg::CrossWidth-1:rsti_pkg::SplitLow]);
      end
      slo_in = LoSum'(plo_ff[0]) + LoSum'(plo_ff[1]) + LoSum'(plo_ff[2]);
      shi_in = HiSum'(phi_ff[0]) + HiSum'(phi_ff[1]) + HiSum'(phi_ff[2]);
      dot_in = (rsti_pkg::DotWidth'(shi_ff) <<< rsti_pkg::SplitLow)
               + rsti_pkg::DotWidth'(slo_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv_mul) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
      if (ctrl.adv_sum) begin
         slo_ff <= slo_in;
         shi_ff <= shi_in;
      end
      if (ctrl.adv_out) begin
         dot_ff <= dot_in;
      end
   end

   assign dot = dot_ff;

endmodule

// ===== hw/rtl/ray_segment_triangle_intersect.sv =====
// Moller-Trumbore hit test of one ray or segment, held in the csr_ registers, against a
// stream of triangles, one triangle per req_ item. The pipeline is eight register stages
// deep: edge subtraction, cross-product multiplies, cross-product differences, three
// stages of split dot products, sign correction and the final compares. One triangle
// is taken every cycle while rsp_stall is low. Stalls hold each stage only while the
// stage after it is full, so bubbles close up and req_stall rises only when all
// stages hold items.
// Write the csr_ registers only while the pipeline is empty; csr_ready is always high.
module ray_segment_triangle_intersect (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_a_x,
   input  logic signed [31:0]  req_a_y,
   input  logic signed [31:0]  req_a_z,
   input  logic signed [31:0]  req_b_x,
   input  logic signed [31:0]  req_b_y,
   input  logic signed [31:0]  req_b_z,
   input  logic signed [31:0]  req_c_x,
   input  logic signed [31:0]  req_c_y,
   input  logic signed [31:0]  req_c_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_hit,
   output logic [2:0]          rsp_miss_reason,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [39:0]         csr_data
);

   localparam int EW = rsti_pkg::EdgeWidth;
   localparam int PW = rsti_pkg::ProdWidth;
   localparam int XW = rsti_pkg::CrossWidth;
   localparam int DW = rsti_pkg::DotWidth;
   localparam int CW = rsti_pkg::CmpWidth;
   localparam int NS = 8;

   logic                mode_ff;
   logic signed [31:0]  start_ff [3];
   logic signed [31:0]  second_ff [3];
   logic [rsti_pkg::ThrWidth-1:0] thr_ff;

   logic [NS:1] v_ff;
   logic [NS:1] adv;

   logic signed [31:0]  va [3];
   logic signed [31:0]  vb [3];
   logic signed [31:0]  vc [3];

   logic signed [EW-1:0] e1_in [3], e2_in [3], tv_in [3], dir_in [3];
   logic signed [EW-1:0] e1_ff [3], e2_ff [3], tv_ff [3], dir_ff [3];
   logic signed [EW-1:0] e1_s2_ff [3], e2_s2_ff [3], tv_s2_ff [3], dir_s2_ff [3];
   logic signed [EW-1:0] e1_s3_ff [3], e2_s3_ff [3], tv_s3_ff [3], dir_s3_ff [3];
   logic signed [PW-1:0] pp_in [6], qp_in [6];
   logic signed [PW-1:0] pp_ff [6], qp_ff [6];
   logic signed [XW-1:0] pv_in [3], qv_in [3];
   logic signed [XW-1:0] pv_ff [3], qv_ff [3];

   rsti_pkg::dot_ctrl_type dot_ctrl;
   logic signed [DW-1:0] det, un, vn, tn;

   logic signed [CW-1:0] dabs_in, un_in, uv_in, vn_in, tn_in;
   logic signed [CW-1:0] dabs_ff, un_ff, uv_ff, vn_ff, tn_ff;
   logic signed [CW-1:0] thr_ext;

   rsti_pkg::reason_type reason_in;
   rsti_pkg::reason_type reason_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         start_ff  <= '{default: '0};
         second_ff <= '{default: '0};
         thr_ff    <= rsti_pkg::ThrReset;
      end else if (csr_valid) begin
         unique case (rsti_pkg::csr_index_type'(csr_index))
            rsti_pkg::CSR_TEST_MODE:     mode_ff      <= csr_data[0];
            rsti_pkg::CSR_START_X:       start_ff[0]  <= csr_data[31:0];
            rsti_pkg::CSR_START_Y:       start_ff[1]  <= csr_data[31:0];
            rsti_pkg::CSR_START_Z:       start_ff[2]  <= csr_data[31:0];
            rsti_pkg::CSR_SECOND_X:      second_ff[0] <= csr_data[31:0];
            rsti_pkg::CSR_SECOND_Y:      second_ff[1] <= csr_data[31:0];
            rsti_pkg::CSR_SECOND_Z:      second_ff[2] <= csr_data[31:0];
            rsti_pkg::CSR_DET_THRESHOLD: thr_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      adv[NS] = !v_ff[NS] || !rsp_stall;
      for (int k = NS - 1; k >= 1; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign req_stall = !adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[1]) v_ff[1] <= req_valid;
         for (int k = 2; k <= NS; k++) begin
            if (adv[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_comb begin
      va = '{req_a_x, req_a_y, req_a_z};
      vb = '{req_b_x, req_b_y, req_b_z};
      vc = '{req_c_x, req_c_y, req_c_z};
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = rsti_pkg::ext33(vb[i]) - rsti_pkg::ext33(va[i]);
         e2_in[i] = rsti_pkg::ext33(vc[i]) - rsti_pkg::ext33(va[i]);
         tv_in[i] = rsti_pkg::ext33(start_ff[i]) - rsti_pkg::ext33(va[i]);
         dir_in[i] = mode_ff ? rsti_pkg::ext33(second_ff[i]) - rsti_pkg::ext33(start_ff[i])
                             : rsti_pkg::ext33(second_ff[i]);
      end
      pp_in[0] = dir_ff[1] * e2_ff[2];
      pp_in[1] = dir_ff[2] * e2_ff[1];
      pp_in[2] = dir_ff[2] * e2_ff[0];
      pp_in[3] = dir_ff[0] * e2_ff[2];
      pp_in[4] = dir_ff[0] * e2_ff[1];
      pp_in[5] = dir_ff[1] * e2_ff[0];
      qp_in[0] = tv_ff[1] * e1_ff[2];
      qp_in[1] = tv_ff[2] * e1_ff[1];
      qp_in[2] = tv_ff[2] * e1_ff[0];
      qp_in[3] = tv_ff[0] * e1_ff[2];
      qp_in[4] = tv_ff[0] * e1_ff[1];
      qp_in[5] = tv_ff[1] * e1_ff[0];
      for (int i = 0; i < 3; i++) begin
         pv_in[i] = XW'(pp_ff[2*i]) - XW'(pp_ff[2*i+1]);
         qv_in[i] = XW'(qp_ff[2*i]) - XW'(qp_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         e1_ff <= e1_in;  e2_ff <= e2_in;  tv_ff <= tv_in;  dir_ff <= dir_in;
      end
      if (adv[2]) begin
         pp_ff <= pp_in;  qp_ff <= qp_in;
         e1_s2_ff <= e1_ff;  e2_s2_ff <= e2_ff;  tv_s2_ff <= tv_ff;  dir_s2_ff <= dir_ff;
      end
      if (adv[3]) begin
         pv_ff <= pv_in;  qv_ff <= qv_in;
         e1_s3_ff <= e1_s2_ff;  e2_s3_ff <= e2_s2_ff;
         tv_s3_ff <= tv_s2_ff;  dir_s3_ff <= dir_s2_ff;
      end
   end

   assign dot_ctrl = '{adv_mul: adv[4], adv_sum: adv[5], adv_out: adv[6]};

   rsti_dot3 u_det (.clock(clock), .ctrl(dot_ctrl), .a(e1_s3_ff),  .b(pv_ff), .dot(det));
   rsti_dot3 u_un  (.clock(clock), .ctrl(dot_ctrl), .a(tv_s3_ff),  .b(pv_ff), .dot(un));
   rsti_dot3 u_vn  (.clock(clock), .ctrl(dot_ctrl), .a(dir_s3_ff), .b(qv_ff), .dot(vn));
   rsti_dot3 u_tn  (.clock(clock), .ctrl(dot_ctrl), .a(e2_s3_ff),  .b(qv_ff), .dot(tn));

   always_comb begin
      if (det[DW-1]) begin
         dabs_in = -CW'(det);
         un_in   = -CW'(un);
         vn_in   = -CW'(vn);
         tn_in   = -CW'(tn);
         uv_in   = -(CW'(un) + CW'(vn));
      end else begin
         dabs_in = CW'(det);
         un_in   = CW'(un);
         vn_in   = CW'(vn);
         tn_in   = CW'(tn);
         uv_in   = CW'(un) + CW'(vn);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         dabs_ff <= dabs_in;  un_ff <= un_in;  vn_ff <= vn_in;
         tn_ff <= tn_in;  uv_ff <= uv_in;
      end
   end

   assign thr_ext = $signed({{(CW - rsti_pkg::ThrWidth){1'b0}}, thr_ff});

   always_comb begin
      if (dabs_ff == '0 || dabs_ff < thr_ext) begin
         reason_in = rsti_pkg::REASON_PARALLEL;
      end else if (un_ff[CW-1] || dabs_ff < un_ff) begin
         reason_in = rsti_pkg::REASON_U_OUT;
      end else if (vn_ff[CW-1] || dabs_ff < uv_ff) begin
         reason_in = rsti_pkg::REASON_V_OUT;
      end else if (tn_ff[CW-1] || tn_ff == '0 || (mode_ff && !(tn_ff < dabs_ff))) begin
         reason_in = rsti_pkg::REASON_T_OUT;
      end else begin
         reason_in = rsti_pkg::REASON_HIT;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         reason_ff <= reason_in;
      end
   end

   assign rsp_valid       = v_ff[NS];
   assign rsp_hit         = (reason_ff == rsti_pkg::REASON_HIT);
   assign rsp_miss_reason = reason_ff;

`ifndef NO_ASSERTIONS
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> &v_ff)
      else $error("input stalled while pipeline has a bubble");

   a_stage1_hold: assert property (@(posedge clock) disable iff (reset)
      v_ff[1] && !adv[1] |=> v_ff[1])
      else $error("stalled item dropped from first stage");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      v_ff[NS] && rsp_stall |=> v_ff[NS] && reason_ff == $past(reason_ff))
      else $error("stalled result changed");
`endif

endmodule

// ===== verif/tb_ray_segment_triangle_intersect.sv =====
`timescale 1ns / 1ps

module tb_ray_segment_triangle_intersect;

   localparam int ONE = 65536;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 250;

   typedef logic signed [127:0] wide_type;
   typedef struct {
      logic signed [31:0] v[9];
   } triangle_type;

   class hit_scoreboard;
      logic                 seg_mode;
      logic signed [31:0]   origin[3];
      logic signed [31:0]   second[3];
      logic [39:0]          det_limit;
      rsti_pkg::reason_type pending[$];
      int                   mismatches;
      int                   checked;
      int                   hits;

      function new();
         seg_mode = 1'b0;
         foreach (origin[i]) begin
            origin[i] = '0;
            second[i] = '0;
         end
         det_limit = rsti_pkg::ThrReset;
         mismatches = 0;
         checked = 0;
         hits = 0;
      endfunction

      function void write_reg(rsti_pkg::csr_index_type idx, logic [39:0] data);
         case (idx)
            rsti_pkg::CSR_TEST_MODE:     seg_mode = data[0];
            rsti_pkg::CSR_START_X:       origin[0] = data[31:0];
            rsti_pkg::CSR_START_Y:       origin[1] = data[31:0];
            rsti_pkg::CSR_START_Z:       origin[2] = data[31:0];
            rsti_pkg::CSR_SECOND_X:      second[0] = data[31:0];
            rsti_pkg::CSR_SECOND_Y:      second[1] = data[31:0];
            rsti_pkg::CSR_SECOND_Z:      second[2] = data[31:0];
            rsti_pkg::CSR_DET_THRESHOLD: det_limit = data;
            default: ;
         endcase
      endfunction

      function void cross3(input wide_type a[3], input wide_type b[3], output wide_type r[3]);
         r[0] = a[1] * b[2] - a[2] * b[1];
         r[1] = a[2] * b[0] - a[0] * b[2];
         r[2] = a[0] * b[1] - a[1] * b[0];
      endfunction

      function wide_type dot3(input wide_type a[3], input wide_type b[3]);
         return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
      endfunction

      function rsti_pkg::reason_type classify(triangle_type t);
         wide_type dir[3], e1[3], e2[3], tv[3], pv[3], qv[3];
         wide_type det, un, vn, tn, lim;
         for (int i = 0; i < 3; i++) begin
            dir[i] = seg_mode ? wide_type'(second[i]) - wide_type'(origin[i])
                              : wide_type'(second[i]);
            e1[i] = wide_type'(t.v[3 + i]) - wide_type'(t.v[i]);
            e2[i] = wide_type'(t.v[6 + i]) - wide_type'(t.v[i]);
            tv[i] = wide_type'(origin[i]) - wide_type'(t.v[i]);
         end
         cross3(dir, e2, pv);
         cross3(tv, e1, qv);
         det = dot3(e1, pv);
         un = dot3(tv, pv);
         vn = dot3(dir, qv);
         tn = dot3(e2, qv);
         if (det < 0) begin
            det = -det;
            un = -un;
            vn = -vn;
            tn = -tn;
         end
         lim = wide_type'({88'b0, det_limit});
         if (det == 0 || det < lim) return rsti_pkg::REASON_PARALLEL;
         if (un < 0 || un > det) return rsti_pkg::REASON_U_OUT;
         if (vn < 0 || un + vn > det) return rsti_pkg::REASON_V_OUT;
         if (tn <= 0) return rsti_pkg::REASON_T_OUT;
         if (seg_mode && tn >= det) return rsti_pkg::REASON_T_OUT;
         return rsti_pkg::REASON_HIT;
      endfunction

      function void note_triangle(triangle_type t);
         pending.push_back(classify(t));
      endfunction

      function void check_result(logic hit, logic [2:0] reason);
         rsti_pkg::reason_type want;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: hit=%0d reason=%0d", hit, reason);
            return;
         end
         want = pending.pop_front();
         if (want == rsti_pkg::REASON_HIT) hits++;
         if (hit !== (want == rsti_pkg::REASON_HIT) || reason !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d: expected hit=%0d reason=%0d, got hit=%0d reason=%0d",
                        checked, want == rsti_pkg::REASON_HIT, want, hit, reason);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_a_x, req_a_y, req_a_z;
   logic signed [31:0] req_b_x, req_b_y, req_b_z;
   logic signed [31:0] req_c_x, req_c_y, req_c_z;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_hit;
   logic [2:0]         rsp_miss_reason;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [39:0]        csr_data;

   hit_scoreboard board;
   int cycles;
   int sent;
   int stall_mode;

   ray_segment_triangle_intersect dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_hit, rsp_miss_reason);
      if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 30);
         2: rsp_stall <= ($urandom_range(0, 99) < 75);
         default: rsp_stall <= (cycles % 5 < 2);
      endcase
   end

   task automatic send_triangle(triangle_type t);
      req_valid <= 1'b1;
      {req_a_x, req_a_y, req_a_z} <= {t.v[0], t.v[1], t.v[2]};
      {req_b_x, req_b_y, req_b_z} <= {t.v[3], t.v[4], t.v[5]};
      {req_c_x, req_c_y, req_c_z} <= {t.v[6], t.v[7], t.v[8]};
      do @(posedge clock); while (req_stall);
      board.note_triangle(t);
      sent++;
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(rsti_pkg::csr_index_type idx, logic [39:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_geometry(logic mode, logic signed [31:0] o[3], logic signed [31:0] s[3],
                                logic [39:0] limit);
      write_csr(rsti_pkg::CSR_TEST_MODE, {39'b0, mode});
      write_csr(rsti_pkg::CSR_START_X, {8'b0, o[0]});
      write_csr(rsti_pkg::CSR_START_Y, {8'b0, o[1]});
      write_csr(rsti_pkg::CSR_START_Z, {8'b0, o[2]});
      write_csr(rsti_pkg::CSR_SECOND_X, {8'b0, s[0]});
      write_csr(rsti_pkg::CSR_SECOND_Y, {8'b0, s[1]});
      write_csr(rsti_pkg::CSR_SECOND_Z, {8'b0, s[2]});
      write_csr(rsti_pkg::CSR_DET_THRESHOLD, limit);
   endtask

   function automatic logic signed [31:0] pick_coord(bit full_range);
      if (full_range) return $urandom();
      return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
   endfunction

   function automatic triangle_type tri_of(int ax, int ay, int az, int bx, int by, int bz,
                                           int cx, int cy, int cz);
      triangle_type t;
      t.v = '{ax, ay, az, bx, by, bz, cx, cy, cz};
      return t;
   endfunction

   initial begin
      logic signed [31:0] o[3], s[3];
      logic [39:0] limit;
      triangle_type t;
      bit wide_geom;
      int burst;
      board = new();
      cycles = 0;
      sent = 0;
      stall_mode = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      {req_a_x, req_a_y, req_a_z, req_b_x, req_b_y, req_b_z, req_c_x, req_c_y, req_c_z} = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      o = '{ONE / 4, ONE / 4, -ONE};
      s = '{0, 0, ONE};
      load_geometry(1'b0, o, s, rsti_pkg::ThrReset);
      send_triangle(tri_of(0, 0, 0, ONE, 0, 0, 0, ONE, 0));
      send_triangle(tri_of(ONE, 0, 0, 2 * ONE, 0, 0, ONE, ONE, 0));
      send_triangle(tri_of(0, ONE, 0, ONE, ONE, 0, 0, 2 * ONE, 0));
      send_triangle(tri_of(ONE, -ONE, 0, ONE, ONE, 0, -ONE, ONE, 0));
      send_triangle(tri_of(0, 0, -2 * ONE, ONE, 0, -2 * ONE, 0, ONE, -2 * ONE));
      send_triangle(tri_of(0, 0, 0, 0, 0, ONE, 0, ONE, 0));
      send_triangle(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_triangle(tri_of(0, 0, 0, 2, 0, 0, 0, 2, 0));
      for (int k = 0; k < 9; k++) t.v[k] = 32'sh7fffffff;
      send_triangle(t);
      for (int k = 0; k < 9; k++) t.v[k] = 32'sh80000000;
      send_triangle(t);
      for (int k = 0; k < 9; k++) t.v[k] = k % 2 ? 32'sh7fffffff : 32'sh80000000;
      send_triangle(t);
      for (int k = 0; k < 9; k++) t.v[k] = k % 3 == 0 ? 32'sh80000000 : 32'sh7fffffff;
      send_triangle(t);
      go_idle();

      s = '{ONE / 4, ONE / 4, -ONE / 2};
      load_geometry(1'b1, o, s, 40'd0);
      send_triangle(tri_of(0, 0, 0, ONE, 0, 0, 0, ONE, 0));
      send_triangle(tri_of(0, 0, -3 * ONE / 4, ONE, 0, -3 * ONE / 4, 0, ONE, -3 * ONE / 4));
      send_triangle(tri_of(0, 0, -ONE / 2, ONE, 0, -ONE / 2, 0, ONE, -ONE / 2));
      send_triangle(tri_of(0, 0, 0, 0, 0, ONE, 0, ONE, 0));
      send_triangle(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0));
      go_idle();

      o = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
      s = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
      load_geometry(1'b1, o, s, 40'hff_ffff_ffff);
      send_triangle(tri_of(0, 0, 0, ONE, 0, 0, 0, ONE, 0));
      send_triangle(tri_of(32'sh80000000, 0, 0, 0, 32'sh7fffffff, 0, 0, 0, 32'sh80000000));
      send_triangle(tri_of(-ONE, -ONE, 0, 32'sh7fffffff, 0, 0, 0, 32'sh7fffffff, ONE));
      go_idle();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wide_geom = (ph % 4 == 3);
         for (int k = 0; k < 3; k++) begin
            o[k] = pick_coord(wide_geom);
            s[k] = pick_coord(wide_geom);
         end
         case ($urandom_range(0, 3))
            0: limit = 40'd0;
            1: limit = rsti_pkg::ThrReset;
            2: limit = {$urandom(), 8'($urandom())};
            default: limit = 40'($urandom_range(0, 1 << 20));
         endcase
         if (ph == RANDOM_PHASES - 1) limit = 40'hff_ffff_ffff;
         load_geometry(ph[0], o, s, limit);
         for (int n = 0; n < ITEMS_PER_PHASE; ) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && n < ITEMS_PER_PHASE; b++, n++) begin
               for (int k = 0; k < 9; k++)
                  t.v[k] = pick_coord(wide_geom || $urandom_range(0, 9) == 0);
               send_triangle(t);
            end
            if (ph % 3 != 2 && $urandom_range(0, 1)) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
         go_idle();
      end

      $display("sent %0d triangles over %0d geometry settings, ray and segment modes",
               sent, RANDOM_PHASES + 3);
      $display("checked %0d results, %0d hits, %0d mismatches",
               board.checked, board.hits, board.mismatches);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/rsti_pkg.sv
hw/rtl/rsti_dot3.sv
hw/rtl/ray_segment_triangle_intersect.sv
verif/tb_ray_segment_triangle_intersect.sv
